FILE: rtl/rg32_pkg.sv
// ----------------------------------------------------------------------------
// rg32_pkg
// Shared types, sizes and command codes of the RadioGatun[32] sponge core.
// ----------------------------------------------------------------------------
package rg32_pkg;

	localparam int MILL_LEN     = 19;
	localparam int BELT_COLS    = 13;
	localparam int BELT_LEN     = 39;
	localparam int BLOCK_BYTES  = 12;
	localparam int FINAL_ROUNDS = 17;
	localparam int ROUNDS_W     = 5;

	typedef logic [MILL_LEN-1:0][31:0] mill_t;
	typedef logic [BELT_LEN-1:0][31:0] belt_t;

	// request modes
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_ABSORB  = 2'd0;
	localparam mode_t MODE_FINAL   = 2'd1;
	localparam mode_t MODE_SQUEEZE = 2'd2;
	localparam mode_t MODE_CLEAR   = 2'd3;

	// datapath operations
	typedef logic [2:0] op_t;
	localparam op_t OP_NOP     = 3'd0;
	localparam op_t OP_ABSORB  = 3'd1;
	localparam op_t OP_PAD     = 3'd2;
	localparam op_t OP_SQUEEZE = 3'd3;
	localparam op_t OP_CLEAR   = 3'd4;
	localparam op_t OP_ROUND   = 3'd5;

	localparam logic [1:0] PHASE_RESET = 2'd2;
	localparam logic [7:0] PAD_BYTE    = 8'h01;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

FILE: rtl/rg32_req_if.sv
// ----------------------------------------------------------------------------
// rg32_req_if
// Request channel: mode and message byte with valid/ready.
// ----------------------------------------------------------------------------
interface rg32_req_if;
	import rg32_pkg::*;

	logic       valid;
	logic       ready;
	mode_t      mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);

endinterface

FILE: rtl/rg32_rsp_if.sv
// ----------------------------------------------------------------------------
// rg32_rsp_if
// Response channel: squeezed 32-bit word with valid/ready.
// ----------------------------------------------------------------------------
interface rg32_rsp_if;

	logic        valid;
	logic        ready;
	logic [31:0] out_word;

	modport source (output valid, output out_word, input ready);
	modport sink   (input valid, input out_word, output ready);

endinterface

FILE: rtl/radiogatun32_sponge_core.sv
// ----------------------------------------------------------------------------
// radiogatun32_sponge_core
// RadioGatun[32] sponge for hashing or keyed pseudo-random output.
//
//   channel | dir | payload                 | fires when
//   --------+-----+-------------------------+-------------------------
//   req     | in  | mode[1:0], data_byte[7:0] | req.valid && req.ready
//   rsp     | out | out_word[31:0]          | rsp.valid && rsp.ready
//
// The round unit computes a full belt-mill round combinationally, so a
// block-closing absorb costs nothing extra. Finalize injects the pad byte,
// then runs 17 rounds on the same round unit, with req.ready low meanwhile.
// A squeeze word waits in an output register; outside finalize, req stalls
// only while that word is held by rsp.ready.
// Reset clears mill, belt and byte position and sets the output phase to two.
// ----------------------------------------------------------------------------
module radiogatun32_sponge_core
	import rg32_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	rg32_req_if.sink   req,
	rg32_rsp_if.source rsp
);

	cmd_t cmd;

	rg32_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_data  (req.data_byte),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	rg32_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.out_word (rsp.out_word)
	);

endmodule

FILE: rtl/rg32_ctrl.sv
// ----------------------------------------------------------------------------
// rg32_ctrl
// Sequencer: accepts requests, issues datapath commands, walks the
// finalize rounds and tracks the response register.
// ----------------------------------------------------------------------------
module rg32_ctrl
	import rg32_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  mode_t      req_mode,
	input  logic [7:0] req_data,
	output logic       req_ready,
	input  logic       rsp_ready,
	output logic       rsp_valid,
	output cmd_t       cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_FINAL = 1'b1;

	logic                state_q;
	logic [ROUNDS_W-1:0] rounds_q;
	logic                rsp_valid_q;
	logic                req_fire;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.data = req_data;
		if (state_q == ST_FINAL) begin
			cmd.op = OP_ROUND;
		end else if (req_fire) begin
			case (req_mode)
				MODE_ABSORB:  cmd.op = OP_ABSORB;
				MODE_FINAL:   cmd.op = OP_PAD;
				MODE_SQUEEZE: cmd.op = OP_SQUEEZE;
				MODE_CLEAR:   cmd.op = OP_CLEAR;
				default:      cmd.op = OP_NOP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rounds_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the response once transferred, load a new one on squeeze
			rsp_valid_q <= (req_fire && req_mode == MODE_SQUEEZE) ||
				(rsp_valid_q && !rsp_ready);

			case (state_q)
				ST_IDLE: begin
					if (req_fire && req_mode == MODE_FINAL) begin
						rounds_q <= ROUNDS_W'(FINAL_ROUNDS);
						state_q  <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					rounds_q <= rounds_q - 1'b1;
					if (rounds_q == ROUNDS_W'(1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/rg32_datapath.sv
// ----------------------------------------------------------------------------
// rg32_datapath
// Mill and belt registers, byte injection, one belt-mill round per cycle,
// output phase and the response word register.
// ----------------------------------------------------------------------------
module rg32_datapath
	import rg32_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output logic [31:0] out_word
);

	mill_t       mill_q, mill_i, mill_r, mill_sel;
	belt_t       belt_q, belt_i, belt_r, belt_fed;
	mill_t       tmp;
	logic [3:0]  pos_q, pos_p, pos_inc;
	logic [1:0]  phase_q, phase_nx;
	logic [7:0]  inj_byte;
	logic [31:0] inj_word;
	logic [31:0] out_word_q;
	logic        wrap;

	function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	// byte injection: little-endian lane of belt row column 0 and mill word 16+row
	always_comb begin
		pos_p    = (pos_q >= 4'(BLOCK_BYTES)) ? 4'd0 : pos_q;
		pos_inc  = pos_p + 4'd1;
		wrap     = (pos_inc == 4'(BLOCK_BYTES));
		inj_byte = (cmd.op == OP_PAD) ? PAD_BYTE : cmd.data;
		inj_word = {24'd0, inj_byte} << {pos_p[1:0], 3'b000};
		mill_i   = mill_q;
		belt_i   = belt_q;
		if (cmd.op == OP_ABSORB || cmd.op == OP_PAD) begin
			case (pos_p[3:2])
				2'd0: begin
					belt_i[0]  = belt_q[0] ^ inj_word;
					mill_i[16] = mill_q[16] ^ inj_word;
				end
				2'd1: begin
					belt_i[BELT_COLS]  = belt_q[BELT_COLS] ^ inj_word;
					mill_i[17]         = mill_q[17] ^ inj_word;
				end
				2'd2: begin
					belt_i[2*BELT_COLS] = belt_q[2*BELT_COLS] ^ inj_word;
					mill_i[18]          = mill_q[18] ^ inj_word;
				end
				default: ;
			endcase
		end
	end

	// one belt-mill round
	always_comb begin
		int sh;
		int j;
		belt_fed = belt_i;
		for (int i = 0; i < 12; i++)
			belt_fed[(i % 3) * BELT_COLS + i] = belt_i[(i % 3) * BELT_COLS + i] ^ mill_i[i + 1];

		sh = 0;
		for (int i = 0; i < MILL_LEN; i++) begin
			j      = (7 * i) % MILL_LEN;
			sh     = (sh + i) & 31;
			tmp[i] = rotr(mill_i[j] ^ (mill_i[(j + 1) % MILL_LEN] | ~mill_i[(j + 2) % MILL_LEN]),
				sh);
		end

		for (int i = 0; i < MILL_LEN; i++)
			mill_r[i] = tmp[i] ^ tmp[(i + 1) % MILL_LEN] ^ tmp[(i + 4) % MILL_LEN];
		mill_r[0] = mill_r[0] ^ 32'd1;

		// each row turns by one column; the word that wraps feeds the mill
		for (int r = 0; r < 3; r++) begin
			for (int k = 1; k < BELT_COLS; k++)
				belt_r[r * BELT_COLS + k] = belt_fed[r * BELT_COLS + k - 1];
			belt_r[r * BELT_COLS] = belt_fed[r * BELT_COLS + BELT_COLS - 1];
			mill_r[13 + r] = mill_r[13 + r] ^ belt_fed[r * BELT_COLS + BELT_COLS - 1];
		end
	end

	assign phase_nx = phase_q ^ 2'b11;
	assign mill_sel = phase_q[1] ? mill_r : mill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mill_q  <= '0;
			belt_q  <= '0;
			pos_q   <= '0;
			phase_q <= PHASE_RESET;
		end else begin
			case (cmd.op)
				OP_ABSORB: begin
					mill_q <= wrap ? mill_r : mill_i;
					belt_q <= wrap ? belt_r : belt_i;
					pos_q  <= wrap ? 4'd0 : pos_inc;
				end
				OP_PAD: begin
					mill_q  <= mill_i;
					belt_q  <= belt_i;
					pos_q   <= 4'd0;
					phase_q <= PHASE_RESET;
				end
				OP_SQUEEZE: begin
					if (phase_q[1]) begin
						mill_q <= mill_r;
						belt_q <= belt_r;
					end
					phase_q <= phase_nx;
				end
				OP_ROUND: begin
					mill_q <= mill_r;
					belt_q <= belt_r;
				end
				OP_CLEAR: begin
					mill_q  <= '0;
					belt_q  <= '0;
					pos_q   <= '0;
					phase_q <= PHASE_RESET;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SQUEEZE)
			out_word_q <= mill_sel[{3'b000, phase_nx}];
	end

	assign out_word = out_word_q;

endmodule
